// ===== src/qmn_pkg.sv =====
// Package for the normalised quaternion product: widths and item types.
`default_nettype none
package qmn_pkg;

	// component format: signed, two integer bits
	localparam int COMPONENT_WIDTH = 16;
	localparam int CW = COMPONENT_WIDTH;
	localparam int FB = CW - 2;
	// right shift on each partial product, keeps the sums inside 31 bits
	localparam int SH = (2 * CW > 31) ? (2 * CW - 31) : 0;
	// signed product component and its magnitude
	localparam int PW = 2 * CW - SH + 1;
	localparam int PM = PW - 1;
	// sum of squares and its integer square root
	localparam int SW = 2 * PM + 2;
	localparam int RB = PM + 1;

	typedef struct packed {
		logic signed [CW-1:0] a_w;
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_z;
		logic signed [CW-1:0] b_w;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_z;
	} qmn_in_t;

	typedef struct packed {
		logic signed [CW-1:0] r_w;
		logic signed [CW-1:0] r_x;
		logic signed [CW-1:0] r_y;
		logic signed [CW-1:0] r_z;
		logic                 zero_magnitude;
	} qmn_out_t;

endpackage
`default_nettype wire

// ===== src/qmn_product.sv =====
// Hamilton product: sixteen multipliers, then truncated terms summed per component.
`default_nettype none
module qmn_product (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic                                 in_valid,
	input  wire qmn_pkg::qmn_in_t                     operand,
	output logic                                      out_valid,
	output logic [3:0][qmn_pkg::PW-1:0]               p
);
	import qmn_pkg::*;

	logic signed [CW-1:0]   a_c [4];
	logic signed [CW-1:0]   b_c [4];
	logic signed [2*CW-1:0] prod_s1 [16];
	logic                   valid_s1;
	logic [PW-1:0]          t_c [16];
	logic [3:0][PW-1:0]     p_s2;
	logic                   valid_s2;

	// magnitude truncated by SH bits, sign restored
	function automatic logic [PW-1:0] term(input logic signed [2*CW-1:0] t);
		logic [2*CW-1:0] mag;
		logic [PW-1:0]   ext;
		mag  = t[2*CW-1] ? (2*CW)'(-t) : t;
		ext  = PW'(mag >> SH);
		term = t[2*CW-1] ? PW'(-ext) : ext;
	endfunction

	assign a_c[0] = operand.a_w;
	assign a_c[1] = operand.a_x;
	assign a_c[2] = operand.a_y;
	assign a_c[3] = operand.a_z;
	assign b_c[0] = operand.b_w;
	assign b_c[1] = operand.b_x;
	assign b_c[2] = operand.b_y;
	assign b_c[3] = operand.b_z;

	// stage 1: all partial products, index a*4+b
	always_ff @(posedge clk) begin
		if (en) begin
			for (int u = 0; u < 4; u++) begin
				for (int v = 0; v < 4; v++) begin
					prod_s1[u*4+v] <= a_c[u] * b_c[v];
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			t_c[k] = term(prod_s1[k]);
		end
	end

	// stage 2: component sums
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= t_c[0]  - t_c[5]  - t_c[10] - t_c[15];
			p_s2[1] <= t_c[1]  + t_c[4]  + t_c[11] - t_c[14];
			p_s2[2] <= t_c[2]  - t_c[7]  + t_c[8]  + t_c[13];
			p_s2[3] <= t_c[3]  + t_c[6]  - t_c[9]  + t_c[12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign p         = p_s2;
	assign out_valid = valid_s2;

endmodule
`default_nettype wire

// ===== src/qmn_sqrt.sv =====
// Magnitudes, sum of squares and a pipelined bit-by-bit integer square root.
`default_nettype none
module qmn_sqrt #(
	parameter int PW = 32,
	parameter int PM = 31,
	parameter int SW = 64,
	parameter int RB = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [3:0][PW-1:0]  p,
	output logic                     out_valid,
	output logic [3:0][PM-1:0]       mag,
	output logic [3:0]               neg,
	output logic [RB-1:0]            root
);
	localparam int RW = RB + 2;

	logic [3:0][PM-1:0]   mag_c;
	logic [3:0][PM-1:0]   mag_sa;
	logic [3:0]           neg_sa;
	logic [3:0][2*PM-1:0] sq_sa;
	logic                 valid_sa;
	logic [3:0][PM-1:0]   mag_sb;
	logic [3:0]           neg_sb;
	logic [SW-1:0]        sum_sb;
	logic                 valid_sb;

	// root iteration pipeline, entry 0 fed from the sum stage
	logic [RW-1:0]        rem_s   [RB+1];
	logic [RB-1:0]        root_s  [RB+1];
	logic [SW-1:0]        sum_s   [RB+1];
	logic [3:0][PM-1:0]   mag_s   [RB+1];
	logic [3:0]           neg_s   [RB+1];
	logic                 valid_s [RB+1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = p[i][PW-1] ? PM'(-p[i]) : PM'(p[i]);
		end
	end

	// stage A: magnitudes and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_sa[i] <= mag_c[i];
				neg_sa[i] <= p[i][PW-1];
				sq_sa[i]  <= mag_c[i] * mag_c[i];
			end
		end
	end

	// stage B: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			mag_sb <= mag_sa;
			neg_sb <= neg_sa;
			sum_sb <= SW'(sq_sa[0]) + SW'(sq_sa[1]) + SW'(sq_sa[2]) + SW'(sq_sa[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sa <= 1'b0;
			valid_sb <= 1'b0;
		end else if (en) begin
			valid_sa <= in_valid;
			valid_sb <= valid_sa;
		end
	end

	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign sum_s[0]   = sum_sb;
	assign mag_s[0]   = mag_sb;
	assign neg_s[0]   = neg_sb;
	assign valid_s[0] = valid_sb;

	// one root bit per stage, two radicand bits brought down each time
	for (genvar j = 0; j < RB; j++) begin : g_root
		logic [RW+1:0] rem2;
		logic [RW+1:0] trial;
		logic          ge;

		assign rem2  = {rem_s[j], sum_s[j][SW-1-2*j -: 2]};
		assign trial = (RW+2)'({root_s[j], 2'b01});
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
				root_s[j+1] <= {root_s[j][RB-2:0], ge};
				sum_s[j+1]  <= sum_s[j];
				mag_s[j+1]  <= mag_s[j];
				neg_s[j+1]  <= neg_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end
	end

	assign out_valid = valid_s[RB];
	assign mag       = mag_s[RB];
	assign neg       = neg_s[RB];
	assign root      = root_s[RB];

endmodule
`default_nettype wire

// ===== src/qmn_divide.sv =====
// One component lane: rounded quotient by restoring division, saturated to the format.
`default_nettype none
module qmn_divide #(
	parameter int W  = 16,
	parameter int FB = 14,
	parameter int PM = 31,
	parameter int RB = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [PM-1:0] mag,
	input  wire logic          neg,
	input  wire logic [RB-1:0] root,
	output logic               out_valid,
	output logic [W-1:0]       r,
	output logic               zero
);
	localparam int QB = W + 1;
	localparam int NW = PM + FB + 3;
	localparam int DW = RB + 1;
	localparam logic [QB-1:0] LIM_NEG = QB'(1) << (W - 1);
	localparam logic [QB-1:0] LIM_POS = LIM_NEG - QB'(1);
	localparam logic [W-1:0]  MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MIN_NEG = {1'b1, {(W-1){1'b0}}};

	logic [NW-1:0] num_c;
	logic [NW-1:0] hi_c;
	logic [DW-1:0] den_c;

	logic [DW-1:0] rem_s   [QB+1];
	logic [QB-1:0] quo_s   [QB+1];
	logic [QB-1:0] low_s   [QB+1];
	logic [DW-1:0] den_s   [QB+1];
	logic          neg_s   [QB+1];
	logic          ov_s    [QB+1];
	logic          zero_s  [QB+1];
	logic          valid_s [QB+1];

	logic [W-1:0]  r_q;
	logic          zero_q;
	logic          valid_q;

	// numerator and divisor for round half away from zero
	assign num_c = (NW'(mag) << (FB + 1)) + NW'(root);
	assign den_c = {root, 1'b0};
	assign hi_c  = num_c >> QB;

	// stage 0: overflow check, upper numerator bits as first remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DW'(hi_c);
			quo_s[0]  <= '0;
			low_s[0]  <= num_c[QB-1:0];
			den_s[0]  <= den_c;
			neg_s[0]  <= neg;
			ov_s[0]   <= hi_c >= NW'(den_c);
			zero_s[0] <= root == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [DW:0] rem2;
		logic        ge;

		assign rem2 = {rem_s[i], low_s[i][QB-1-i]};
		assign ge   = rem2 >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? DW'(rem2 - {1'b0, den_s[i]}) : DW'(rem2);
				quo_s[i+1]  <= {quo_s[i][QB-2:0], ge};
				low_s[i+1]  <= low_s[i];
				den_s[i+1]  <= den_s[i];
				neg_s[i+1]  <= neg_s[i];
				ov_s[i+1]   <= ov_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end
	end

	// sign, saturation and the zero-magnitude case
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= zero_s[QB];
			if (zero_s[QB]) begin
				r_q <= '0;
			end else if (neg_s[QB]) begin
				r_q <= (ov_s[QB] || quo_s[QB] > LIM_NEG) ? MIN_NEG : W'(-quo_s[QB]);
			end else begin
				r_q <= (ov_s[QB] || quo_s[QB] > LIM_POS) ? MAX_POS : W'(quo_s[QB]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_s[QB];
		end
	end

	assign out_valid = valid_q;
	assign r         = r_q;
	assign zero      = zero_q;

endmodule
`default_nettype wire

// ===== src/quaternion_multiply_normalize.sv =====
// Top level of the normalised quaternion product pipeline.
// Usage:
//   operand channel: operand_valid / operand_stall carry one item with two
//   quaternions in signed Q1.14. result channel: result_valid / result_stall
//   carry the normalised Hamilton product and the zero_magnitude flag.
//   An item moves on a rising edge with valid high and stall low.
// Stages: 2 product stages, 2 square/sum stages, one stage per root bit
//   (PM+1, 32 at the default width), one overflow stage, one stage per
//   quotient bit (COMPONENT_WIDTH+1) and a saturation stage.
// Throughput: one item per cycle while not stalled; every stage is a
//   plain register slice.
// Stall: the whole pipeline holds while a result waits and result_stall is
//   high; operand_stall is raised in the same cycle, so nothing is lost or
//   repeated. Empty slots still advance while no result is waiting.
// Reset: arst_n clears all valid bits; no item is in flight afterwards.
// A zero product gives a zero result with zero_magnitude set.
`default_nettype none
module quaternion_multiply_normalize (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              operand_valid,
	output logic                   operand_stall,
	input  wire qmn_pkg::qmn_in_t  operand,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output qmn_pkg::qmn_out_t      result
);
	import qmn_pkg::*;

	logic                 en;
	logic                 prod_valid;
	logic [3:0][PW-1:0]   p;
	logic                 root_valid;
	logic [3:0][PM-1:0]   mag;
	logic [3:0]           neg;
	logic [RB-1:0]        root;
	logic [3:0][CW-1:0]   r;
	logic [3:0]           zero;
	logic [3:0]           lane_valid;

	// global advance: hold only when a finished item is not taken
	assign en            = !(result_valid && result_stall);
	assign operand_stall = !en;

	qmn_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (operand_valid),
		.operand   (operand),
		.out_valid (prod_valid),
		.p         (p)
	);

	qmn_sqrt #(
		.PW (PW),
		.PM (PM),
		.SW (SW),
		.RB (RB)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prod_valid),
		.p         (p),
		.out_valid (root_valid),
		.mag       (mag),
		.neg       (neg),
		.root      (root)
	);

	// lanes advance together, so their valid bits always agree
	qmn_divide #(
		.W  (CW),
		.FB (FB),
		.PM (PM),
		.RB (RB)
	) u_div_w (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.mag       (mag[0]),
		.neg       (neg[0]),
		.root      (root),
		.out_valid (lane_valid[0]),
		.r         (r[0]),
		.zero      (zero[0])
	);

	for (genvar k = 1; k < 4; k++) begin : g_lane
		qmn_divide #(
			.W  (CW),
			.FB (FB),
			.PM (PM),
			.RB (RB)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (root_valid),
			.mag       (mag[k]),
			.neg       (neg[k]),
			.root      (root),
			.out_valid (lane_valid[k]),
			.r         (r[k]),
			.zero      (zero[k])
		);
	end

	assign result_valid          = &lane_valid;
	assign result.r_w            = r[0];
	assign result.r_x            = r[1];
	assign result.r_y            = r[2];
	assign result.r_z            = r[3];
	assign result.zero_magnitude = zero[0] & zero[1] & zero[2] & zero[3];

endmodule
`default_nettype wire
